>>> sv/scaled_accumulator_alu_unit_defines.svh
// Assertion macros shared by the scaled accumulator RTL.
// No dependencies; expects clk and rst_n in the including module's scope.
`ifndef SCALED_ACCUMULATOR_ALU_UNIT_DEFINES_SVH
`define SCALED_ACCUMULATOR_ALU_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SAL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/sal_pkg.sv
// Shared types and codes for the scaled accumulator unit.
// No dependencies.
package sal_pkg;

  typedef enum logic [3:0] {
    CMD_SET16 = 4'd0,
    CMD_SET32 = 4'd1,
    CMD_ADD16 = 4'd2,
    CMD_ADD32 = 4'd3,
    CMD_SUB32 = 4'd4,
    CMD_MUL16 = 4'd5,
    CMD_DIV16 = 4'd6,
    CMD_GET16 = 4'd7,
    CMD_GET32 = 4'd8,
    CMD_CMP32 = 4'd9
  } cmd_t;

  typedef enum logic [2:0] {
    CMP_EQ = 3'd1,
    CMP_GT = 3'd2,
    CMP_LT = 3'd3,
    CMP_GE = 3'd4,
    CMP_LE = 3'd5
  } cmp_op_t;

  // Request to the iterative multiply/divide unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } mdu_req_t;

  localparam int unsigned MulSteps = 32;
  localparam int unsigned DivSteps = 64;

  // Byte address of base_scale on the APB port.
  localparam logic [1:0] AddrBaseScale = 2'd0;

endpackage

>>> sv/sal_mdu.sv
// Iterative shift-add multiplier / restoring divider, one bit per cycle.
// Depends on sal_pkg (mdu_req_t, step counts).
module sal_mdu (
  input  logic              clk,
  input  logic              rst_n,
  input  sal_pkg::mdu_req_t req,
  input  logic [63:0]       a,
  input  logic [31:0]       b,
  output logic [63:0]       res,
  output logic              done
);

  logic        busy_r;
  logic        div_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] work_r;   // multiplicand, or dividend/quotient shift register
  logic [63:0] prod_r;   // product; low word holds the divisor in divide mode
  logic [31:0] aux_r;    // multiplier bits, or partial remainder

  logic [32:0] shifted;
  logic [32:0] diff;
  logic        q_bit;

  assign shifted = {aux_r, work_r[63]};
  assign diff    = shifted - {1'b0, prod_r[31:0]};
  assign q_bit   = (shifted >= {1'b0, prod_r[31:0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      div_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        div_r  <= req.is_div;
        work_r <= a;
        if (req.is_div) begin
          cnt_r  <= 6'(sal_pkg::DivSteps - 1);
          prod_r <= {32'd0, b};
          aux_r  <= '0;
        end else begin
          cnt_r  <= 6'(sal_pkg::MulSteps - 1);
          prod_r <= '0;
          aux_r  <= b;
        end
      end else if (busy_r) begin
        if (div_r) begin
          aux_r  <= q_bit ? diff[31:0] : shifted[31:0];
          work_r <= {work_r[62:0], q_bit};
        end else begin
          if (aux_r[0]) begin
            prod_r <= prod_r + work_r;
          end
          work_r <= {work_r[62:0], 1'b0};
          aux_r  <= {1'b0, aux_r[31:1]};
        end
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 6'd1;
        end
      end
    end
  end

  assign res  = div_r ? work_r : prod_r;
  assign done = done_r;

endmodule

>>> sv/scaled_accumulator_alu_unit.sv
// Top level of the scaled 64-bit accumulator: APB register, sequencer, output register.
// Depends on sal_pkg, sal_mdu and scaled_accumulator_alu_unit_defines.svh.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------------
//  in_     | input     | in_valid / in_ready     | command, operand_low/high, compare_op
//  out_    | output    | out_valid / out_ready   | word_low, word_high, compare_true,
//          |           |                         | answer_given
//  cfg_    | APB slave | psel/penable/pwrite     | base_scale at byte address 0
//
// Steps: set/add/sub/compare/unknown pass accept, scale, execute, result;
//   mul16 adds 32 shift-add steps, and div16 and get16/get32 the 64-step
//   restoring divider in sal_mdu, which divide of or by zero and readback at base
//   zero skip. All long ops share that one multiply/divide unit.
// Reset: rst_n synchronous, active low; clears accumulator, base_scale and control.
// Stalls: one item in flight; the next item is taken while a result waits in the
//   output register, and a finished result holds in S_DONE until that register frees.
module scaled_accumulator_alu_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input item
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_command,
  input  logic [15:0] in_operand_low,
  input  logic [15:0] in_operand_high,
  input  logic [2:0]  in_compare_op,
  // result item
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_word_low,
  output logic [15:0] out_word_high,
  output logic        out_compare_true,
  output logic        out_answer_given,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

`include "scaled_accumulator_alu_unit_defines.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_EXEC,
    S_WAIT,
    S_FIN,
    S_DONE
  } state_t;

  state_t      state_r;
  logic [15:0] base_r;
  logic [63:0] acc_r;
  logic [3:0]  cmd_r;
  logic [15:0] lo_r;
  logic [15:0] hi_r;
  logic [2:0]  cop_r;
  logic [47:0] opnd_r;     // scaled operand, always nonnegative
  logic        neg_r;      // quotient sign for the divide in flight
  logic [63:0] q_r;        // signed readback quotient
  logic [15:0] res_lo_r;
  logic [15:0] res_hi_r;
  logic        res_ct_r;
  logic        res_ans_r;
  logic        out_valid_r;
  logic [15:0] out_lo_r;
  logic [15:0] out_hi_r;
  logic        out_ct_r;
  logic        out_ans_r;

  logic              cfg_wr;
  logic              in_acc;
  logic              out_stall;
  logic              is32;
  logic [15:0]       hi_eff;
  logic [47:0]       opnd_nxt;
  logic [63:0]       opnd64;
  logic [63:0]       acc_mag;
  logic              acc_lt_v;
  logic              v_lt_acc;
  logic              cmp_hit;
  logic              cmp_ok;
  sal_pkg::mdu_req_t mdu_req;
  logic [63:0]       mdu_a;
  logic [31:0]       mdu_b;
  logic [63:0]       mdu_res;
  logic              mdu_done;
  logic [63:0]       mdu_q;
  logic              q_over16;
  logic              q_over32;

  // ---------------- configuration ----------------
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == sal_pkg::AddrBaseScale);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == sal_pkg::AddrBaseScale) ? {16'd0, base_r} : 32'd0;

  // ---------------- datapath ----------------
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_stall = out_valid_r && !out_ready;

  always_comb begin
    is32   = (cmd_r inside {sal_pkg::CMD_SET32, sal_pkg::CMD_ADD32,
                            sal_pkg::CMD_SUB32, sal_pkg::CMD_CMP32});
    hi_eff = is32 ? hi_r : 16'd0;
  end

  // 32x16 scaling multiply, registered before any use
  assign opnd_nxt = {16'd0, hi_eff, lo_r} * {32'd0, base_r};
  assign opnd64   = {16'd0, opnd_r};
  assign acc_mag  = acc_r[63] ? (64'd0 - acc_r) : acc_r;
  assign acc_lt_v = $signed(acc_r) < $signed(opnd64);
  assign v_lt_acc = $signed(opnd64) < $signed(acc_r);

  always_comb begin
    cmp_ok  = 1'b1;
    cmp_hit = 1'b0;
    case (cop_r)
      sal_pkg::CMP_EQ: cmp_hit = (acc_r == opnd64);
      sal_pkg::CMP_GT: cmp_hit = acc_lt_v;
      sal_pkg::CMP_LT: cmp_hit = v_lt_acc;
      sal_pkg::CMP_GE: cmp_hit = !v_lt_acc;
      sal_pkg::CMP_LE: cmp_hit = !acc_lt_v;
      default:         cmp_ok  = 1'b0;
    endcase
  end

  // Launch of the shared multiply/divide unit from S_EXEC
  always_comb begin
    mdu_req = '0;
    mdu_a   = acc_mag;
    mdu_b   = opnd_r[31:0];
    if (state_r == S_EXEC) begin
      case (cmd_r)
        sal_pkg::CMD_MUL16: begin
          mdu_req.start = 1'b1;
          mdu_a         = acc_r;
        end
        sal_pkg::CMD_DIV16: begin
          mdu_req.start  = (acc_r != '0) && (opnd_r != '0);
          mdu_req.is_div = 1'b1;
        end
        sal_pkg::CMD_GET16, sal_pkg::CMD_GET32: begin
          mdu_req.start  = (base_r != '0);
          mdu_req.is_div = 1'b1;
          mdu_b          = {16'd0, base_r};
        end
        default: mdu_req = '0;
      endcase
    end
  end

  sal_mdu u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mdu_req),
    .a     (mdu_a),
    .b     (mdu_b),
    .res   (mdu_res),
    .done  (mdu_done)
  );

  assign mdu_q = neg_r ? (64'd0 - mdu_res) : mdu_res;

  // readback caps: positive quotient above 16 bits, or shifted quotient above 16 bits
  assign q_over16 = !q_r[63] && (q_r[63:16] != '0);
  assign q_over32 = !q_r[63] && (q_r[63:32] != '0);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        base_r <= cfg_pwdata[15:0];
      end
      // in S_DONE the reload below owns out_valid_r
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r     <= in_command;
            lo_r      <= in_operand_low;
            hi_r      <= in_operand_high;
            cop_r     <= in_compare_op;
            res_lo_r  <= '0;
            res_hi_r  <= '0;
            res_ct_r  <= 1'b0;
            res_ans_r <= 1'b0;
            state_r   <= S_SCALE;
          end
        end
        S_SCALE: begin
          opnd_r  <= opnd_nxt;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          neg_r <= acc_r[63];
          case (cmd_r)
            sal_pkg::CMD_SET16, sal_pkg::CMD_SET32: begin
              acc_r   <= opnd64;
              state_r <= S_DONE;
            end
            sal_pkg::CMD_ADD16, sal_pkg::CMD_ADD32: begin
              acc_r   <= acc_r + opnd64;
              state_r <= S_DONE;
            end
            sal_pkg::CMD_SUB32: begin
              acc_r   <= acc_r - opnd64;
              state_r <= S_DONE;
            end
            sal_pkg::CMD_MUL16: state_r <= S_WAIT;
            sal_pkg::CMD_DIV16: begin
              if (mdu_req.start) begin
                state_r <= S_WAIT;
              end else begin
                acc_r   <= '0;
                state_r <= S_DONE;
              end
            end
            sal_pkg::CMD_GET16, sal_pkg::CMD_GET32: begin
              if (mdu_req.start) begin
                state_r <= S_WAIT;
              end else begin
                q_r     <= '0;
                state_r <= S_FIN;
              end
            end
            sal_pkg::CMD_CMP32: begin
              res_ct_r  <= cmp_ok && cmp_hit;
              res_ans_r <= cmp_ok;
              state_r   <= S_DONE;
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_WAIT: begin
          if (mdu_done) begin
            case (cmd_r)
              sal_pkg::CMD_MUL16: begin
                acc_r   <= mdu_res;
                state_r <= S_DONE;
              end
              sal_pkg::CMD_DIV16: begin
                acc_r   <= mdu_q;
                state_r <= S_DONE;
              end
              default: begin
                q_r     <= mdu_q;
                state_r <= S_FIN;
              end
            endcase
          end
        end
        S_FIN: begin
          res_ans_r <= 1'b1;
          if (cmd_r == sal_pkg::CMD_GET16) begin
            res_lo_r <= q_over16 ? 16'hFFFF : q_r[15:0];
          end else begin
            res_lo_r <= q_r[15:0];
            res_hi_r <= q_over32 ? 16'hFFFF : q_r[31:16];
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_lo_r    <= res_lo_r;
            out_hi_r    <= res_hi_r;
            out_ct_r    <= res_ct_r;
            out_ans_r   <= res_ans_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_word_low     = out_lo_r;
  assign out_word_high    = out_hi_r;
  assign out_compare_true = out_ct_r;
  assign out_answer_given = out_ans_r;

  // ---------------- assertions ----------------
  `SAL_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready, "took a second item while busy")
  `SAL_ASSERT_NOW(a_mdu_done_in_wait, mdu_done, state_r == S_WAIT, "divider result unexpected")
  `SAL_ASSERT_NEXT(a_hold_result, state_r == S_DONE && out_stall, state_r == S_DONE, "result lost")
  `SAL_ASSERT_NOW(a_cmp_implies_ans, out_valid_r && out_ct_r, out_ans_r, "compare without answer")

endmodule

>>> test/tb.sv
// Testbench for scaled_accumulator_alu_unit: directed table, then random phases per base.
// Depends on sal_pkg and the RTL; results are checked against fixed rows or an in-bench predictor.
`timescale 1ns / 1ps

module tb;

  // Codes the package leaves unnamed: invalid compare selects and unused commands.
  localparam logic [2:0] CMP_NONE = 3'd0;
  localparam logic [2:0] CMP_BAD = 3'd7;
  localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic [3:0]  command;
    logic [15:0] op_low;
    logic [15:0] op_high;
    logic [2:0]  cmp_sel;
  } item_t;

  typedef struct packed {
    logic [15:0] word_low;
    logic [15:0] word_high;
    logic        compare_true;
    logic        answer_given;
  } readout_t;

  // One directed row: base to run it under, the item, and a hand-typed readout when fixed.
  typedef struct packed {
    logic [15:0] base;
    item_t       item;
    logic        fixed;
    readout_t    want;
  } row_t;

  localparam readout_t NO_ANSWER = '0;
  localparam logic FIXED = 1'b1;
  localparam logic PREDICT = 1'b0;

  localparam int NUM_ROWS = 28;
  localparam int NUM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 100;

  row_t dir_rows [NUM_ROWS] = '{
    // Reset state: base 0, accumulator 0. Readbacks divide by zero -> 0.
    '{16'd0, '{sal_pkg::CMD_GET16, 16'h0000, 16'h0000, CMP_NONE}, FIXED,
      '{16'h0, 16'h0, 1'b0, 1'b1}},
    '{16'd0, '{sal_pkg::CMD_GET32, 16'h0000, 16'h0000, CMP_NONE}, FIXED,
      '{16'h0, 16'h0, 1'b0, 1'b1}},
    // Base 0 scales any operand to zero.
    '{16'd0, '{sal_pkg::CMD_SET32, 16'hFFFF, 16'hFFFF, CMP_NONE}, FIXED, NO_ANSWER},
    '{16'd0, '{sal_pkg::CMD_CMP32, 16'h1234, 16'h0000, sal_pkg::CMP_EQ}, FIXED,
      '{16'h0, 16'h0, 1'b1, 1'b1}},
    // Base 1: largest 32-bit operand, which only the 16-bit readback cap clips.
    '{16'd1, '{sal_pkg::CMD_SET32, 16'hFFFF, 16'hFFFF, CMP_NONE}, FIXED, NO_ANSWER},
    '{16'd1, '{sal_pkg::CMD_GET32, 16'h0000, 16'h0000, CMP_NONE}, FIXED,
      '{16'hFFFF, 16'hFFFF, 1'b0, 1'b1}},
    '{16'd1, '{sal_pkg::CMD_GET16, 16'h0000, 16'h0000, CMP_NONE}, FIXED,
      '{16'hFFFF, 16'h0, 1'b0, 1'b1}},
    '{16'd1, '{sal_pkg::CMD_CMP32, 16'hFFFF, 16'hFFFF, sal_pkg::CMP_GE}, FIXED,
      '{16'h0, 16'h0, 1'b1, 1'b1}},
    // Invalid compare selects answer nothing.
    '{16'd1, '{sal_pkg::CMD_CMP32, 16'h0000, 16'h0000, CMP_NONE}, FIXED, NO_ANSWER},
    '{16'd1, '{sal_pkg::CMD_CMP32, 16'hFFFF, 16'hFFFF, CMP_BAD}, FIXED, NO_ANSWER},
    '{16'd1, '{sal_pkg::CMD_MUL16, 16'hFFFF, 16'h0000, CMP_NONE}, FIXED, NO_ANSWER},
    '{16'd1, '{sal_pkg::CMD_GET32, 16'h0000, 16'h0000, CMP_NONE}, PREDICT, NO_ANSWER},
    // Unused commands: no answer, state kept.
    '{16'd1, '{CMD_UNUSED_LO, 16'hFFFF, 16'hFFFF, CMP_BAD}, FIXED, NO_ANSWER},
    '{16'd1, '{CMD_UNUSED_HI, 16'hFFFF, 16'hFFFF, CMP_BAD}, FIXED, NO_ANSWER},
    // Negative accumulator: readback gives its low word.
    '{16'd1, '{sal_pkg::CMD_SET16, 16'h0000, 16'h0000, CMP_NONE}, FIXED, NO_ANSWER},
    '{16'd1, '{sal_pkg::CMD_SUB32, 16'h0001, 16'h0000, CMP_NONE}, FIXED, NO_ANSWER},
    '{16'd1, '{sal_pkg::CMD_GET16, 16'h0000, 16'h0000, CMP_NONE}, FIXED,
      '{16'hFFFF, 16'h0, 1'b0, 1'b1}},
    // Divide by a zero operand clears the accumulator.
    '{16'd1, '{sal_pkg::CMD_DIV16, 16'h0000, 16'h0000, CMP_NONE}, FIXED, NO_ANSWER},
    '{16'd1, '{sal_pkg::CMD_GET32, 16'h0000, 16'h0000, CMP_NONE}, FIXED,
      '{16'h0, 16'h0, 1'b0, 1'b1}},
    // Negative dividend truncates toward zero.
    '{16'd1, '{sal_pkg::CMD_SET16, 16'd100, 16'h0000, CMP_NONE}, FIXED, NO_ANSWER},
    '{16'd1, '{sal_pkg::CMD_SUB32, 16'd300, 16'h0000, CMP_NONE}, FIXED, NO_ANSWER},
    '{16'd1, '{sal_pkg::CMD_DIV16, 16'd7, 16'h0000, CMP_NONE}, FIXED, NO_ANSWER},
    '{16'd1, '{sal_pkg::CMD_GET16, 16'h0000, 16'h0000, CMP_NONE}, PREDICT, NO_ANSWER},
    // Largest base with largest operands.
    '{16'hFFFF, '{sal_pkg::CMD_SET16, 16'hFFFF, 16'h0000, CMP_NONE}, FIXED, NO_ANSWER},
    '{16'hFFFF, '{sal_pkg::CMD_ADD32, 16'hFFFF, 16'hFFFF, CMP_NONE}, FIXED, NO_ANSWER},
    '{16'hFFFF, '{sal_pkg::CMD_ADD16, 16'hFFFF, 16'h0000, CMP_NONE}, FIXED, NO_ANSWER},
    '{16'hFFFF, '{sal_pkg::CMD_GET32, 16'h0000, 16'h0000, CMP_NONE}, PREDICT, NO_ANSWER},
    '{16'hFFFF, '{sal_pkg::CMD_CMP32, 16'hFFFF, 16'hFFFF, sal_pkg::CMP_LE}, PREDICT,
      NO_ANSWER}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  in_command;
  logic [15:0] in_operand_low;
  logic [15:0] in_operand_high;
  logic [2:0]  in_compare_op;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_word_low;
  logic [15:0] out_word_high;
  logic        out_compare_true;
  logic        out_answer_given;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predictor state: the accumulator and the base it is scaled by.
  logic [63:0] acc_value;
  logic [15:0] base_value;
  // Last set operand, reused by compares so that equality actually hits.
  logic [15:0] last_set_low;
  logic [15:0] last_set_high;

  readout_t pending_readouts[$];
  int       bad_fields;
  int       results_seen;
  // No idling on either side while set.
  bit       quiet;

  scaled_accumulator_alu_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_operand_low   (in_operand_low),
    .in_operand_high  (in_operand_high),
    .in_compare_op    (in_compare_op),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_word_low     (out_word_low),
    .out_word_high    (out_word_high),
    .out_compare_true (out_compare_true),
    .out_answer_given (out_answer_given),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Signed divide, truncating toward zero; 0 when either side is 0.
  function automatic logic [63:0] div_trunc(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] mag_n;
    logic [63:0] mag_d;
    logic [63:0] quo;
    if (num == 64'd0 || den == 64'd0) return 64'd0;
    mag_n = num[63] ? -num : num;
    mag_d = den[63] ? -den : den;
    quo = mag_n / mag_d;
    return (num[63] != den[63]) ? -quo : quo;
  endfunction

  // Applies one item to the predicted accumulator and returns the readout it causes.
  function automatic readout_t accum_step(input item_t it);
    readout_t    res;
    logic [63:0] scaled16;
    logic [63:0] scaled32;
    logic [63:0] quo;
    logic [63:0] upper;
    res = NO_ANSWER;
    scaled16 = {48'd0, it.op_low} * {48'd0, base_value};
    scaled32 = {32'd0, it.op_high, it.op_low} * {48'd0, base_value};
    case (it.command)
      sal_pkg::CMD_SET16: acc_value = scaled16;
      sal_pkg::CMD_SET32: acc_value = scaled32;
      sal_pkg::CMD_ADD16: acc_value = acc_value + scaled16;
      sal_pkg::CMD_ADD32: acc_value = acc_value + scaled32;
      sal_pkg::CMD_SUB32: acc_value = acc_value - scaled32;
      sal_pkg::CMD_MUL16: acc_value = acc_value * scaled16;
      sal_pkg::CMD_DIV16: acc_value = div_trunc(acc_value, scaled16);
      sal_pkg::CMD_GET16: begin
        quo = div_trunc(acc_value, {48'd0, base_value});
        if (!quo[63] && quo > 64'd65535) quo = 64'd65535;
        res.word_low = quo[15:0];
        res.answer_given = 1'b1;
      end
      sal_pkg::CMD_GET32: begin
        quo = div_trunc(acc_value, {48'd0, base_value});
        res.word_low = quo[15:0];
        upper = $signed(quo) >>> 16;
        if (!upper[63] && upper > 64'hFFFF) upper = 64'hFFFF;
        res.word_high = upper[15:0];
        res.answer_given = 1'b1;
      end
      sal_pkg::CMD_CMP32: begin
        res.answer_given = 1'b1;
        case (it.cmp_sel)
          sal_pkg::CMP_EQ: res.compare_true = (scaled32 == acc_value);
          sal_pkg::CMP_GT: res.compare_true = ($signed(acc_value) < $signed(scaled32));
          sal_pkg::CMP_LT: res.compare_true = ($signed(scaled32) < $signed(acc_value));
          sal_pkg::CMP_GE: res.compare_true = !($signed(scaled32) < $signed(acc_value));
          sal_pkg::CMP_LE: res.compare_true = !($signed(acc_value) < $signed(scaled32));
          default: res.answer_given = 1'b0;
        endcase
      end
      default: ;
    endcase
    return res;
  endfunction

  // Mostly zero, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Operand words lean toward 0, all ones and small values.
  function automatic logic [15:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    if (r < 6) return 16'($urandom_range(0, 20));
    return 16'($urandom);
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    r;
    it.op_low = pick_word();
    it.op_high = ($urandom_range(0, 9) < 4) ? 16'h0000 : pick_word();
    it.cmp_sel = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 5)) : 3'($urandom);
    r = $urandom_range(0, 99);
    if (r < 10) it.command = sal_pkg::CMD_SET16;
    else if (r < 20) it.command = sal_pkg::CMD_SET32;
    else if (r < 28) it.command = sal_pkg::CMD_ADD16;
    else if (r < 36) it.command = sal_pkg::CMD_ADD32;
    else if (r < 44) it.command = sal_pkg::CMD_SUB32;
    else if (r < 50) it.command = sal_pkg::CMD_MUL16;
    else if (r < 58) it.command = sal_pkg::CMD_DIV16;
    else if (r < 70) it.command = sal_pkg::CMD_GET16;
    else if (r < 82) it.command = sal_pkg::CMD_GET32;
    else if (r < 97) it.command = sal_pkg::CMD_CMP32;
    else it.command = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    // Multiply grows the accumulator fast; keep its operand small most of the time.
    if (it.command == sal_pkg::CMD_MUL16 && $urandom_range(0, 3) != 0)
      it.op_low = 16'($urandom_range(0, 5));
    if (it.command == sal_pkg::CMD_SET16) begin
      last_set_low = it.op_low;
      last_set_high = 16'h0000;
    end
    if (it.command == sal_pkg::CMD_SET32) begin
      last_set_low = it.op_low;
      last_set_high = it.op_high;
    end
    if (it.command == sal_pkg::CMD_CMP32 && $urandom_range(0, 1) == 1) begin
      it.op_low = last_set_low;
      it.op_high = last_set_high;
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("result %0d: %s got %0h want %0h (%0t)", results_seen, what, got, want, $time);
    bad_fields++;
  endtask

  // Sends one item; valid stays high after acceptance until the next call or a drain.
  task automatic push_item(input item_t it, input logic fixed, input readout_t want);
    readout_t predicted;
    int       gap;
    gap = quiet ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_command = it.command;
    in_operand_low = it.op_low;
    in_operand_high = it.op_high;
    in_compare_op = it.cmp_sel;
    do @(posedge clk); while (!in_ready);
    predicted = accum_step(it);
    pending_readouts.push_back(fixed ? want : predicted);
  endtask

  // Drops valid and waits until every expected readout has come back.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
  endtask

  // APB write of base_scale, then a read to confirm it took.
  task automatic set_base(input logic [15:0] val);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = sal_pkg::AddrBaseScale;
    cfg_pwdata = {16'd0, val};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    base_value = val;
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {16'd0, val})
      report_mismatch("base_scale readback", 64'(cfg_prdata), 64'(val));
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // Result side: compare each accepted readout with the oldest expectation.
  always @(posedge clk) begin
    readout_t head;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readouts.size() == 0) begin
        report_mismatch("readout with nothing expected",
                        64'({out_word_high, out_word_low}), 64'd0);
      end else begin
        head = pending_readouts.pop_front();
        if (out_word_low !== head.word_low)
          report_mismatch("word_low", 64'(out_word_low), 64'(head.word_low));
        if (out_word_high !== head.word_high)
          report_mismatch("word_high", 64'(out_word_high), 64'(head.word_high));
        if (out_compare_true !== head.compare_true)
          report_mismatch("compare_true", 64'(out_compare_true), 64'(head.compare_true));
        if (out_answer_given !== head.answer_given)
          report_mismatch("answer_given", 64'(out_answer_given), 64'(head.answer_given));
      end
      results_seen++;
    end
  end

  // Receiver back-pressure: random stalls unless a quiet stretch is running.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet || !rst_n) begin
        out_ready = rst_n;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("[scaled_accumulator_alu_unit] ERROR");
    $finish;
  end

  initial begin
    logic [15:0] phase_base [NUM_PHASES];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = sal_pkg::CMD_SET16;
    in_operand_low = 16'h0000;
    in_operand_high = 16'h0000;
    in_compare_op = CMP_NONE;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = sal_pkg::AddrBaseScale;
    cfg_pwdata = 32'd0;
    acc_value = 64'd0;
    base_value = 16'd0;
    last_set_low = 16'h0000;
    last_set_high = 16'h0000;
    bad_fields = 0;
    results_seen = 0;
    quiet = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table; a base change drains the block before the register write.
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (dir_rows[i].base != base_value) begin
        drain();
        set_base(dir_rows[i].base);
      end
      push_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want);
    end

    // Random phases, each under its own base; 0 and all ones cover the extremes.
    phase_base[0] = 16'd1;
    phase_base[1] = 16'hFFFF;
    phase_base[2] = 16'd0;
    phase_base[3] = 16'd2;
    phase_base[4] = 16'($urandom);
    phase_base[5] = 16'd3;
    phase_base[6] = 16'($urandom_range(1, 300));
    phase_base[7] = 16'd7;
    for (int p = 0; p < NUM_PHASES; p++) begin
      // Sender holds off until the block is empty before every register write.
      drain();
      set_base(phase_base[p]);
      quiet = (p % 3 == 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) push_item(random_item(), PREDICT, NO_ANSWER);
    end

    drain();
    quiet = 1'b0;
    // Leave room for any stray readout.
    repeat (200) @(posedge clk);
    if (bad_fields == 0) begin
      $display("[scaled_accumulator_alu_unit] OK");
    end else begin
      $display("[scaled_accumulator_alu_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/sal_pkg.sv
sv/sal_mdu.sv
sv/scaled_accumulator_alu_unit.sv
test/tb.sv
